// ===== rtl/core/tpr_pkg.sv =====
// Package for the tape pulse run generator.
// Holds field widths, operation codes, conversion constants and the structs
// shared by the core modules. Depends on nothing.
package tpr_pkg;

    localparam int OP_W     = 2;
    localparam int DUR_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int USED_W   = 4;
    localparam int COUNT_W  = 22;
    localparam int STEP_W   = 4;
    localparam int LEN_W    = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [OP_W-1:0] OP_PULSE = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
    localparam logic [OP_W-1:0] OP_PAUSE = 2'd2;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ZERO_LEN = 1'b0;
    localparam logic REG_ONE_LEN  = 1'b1;

    localparam logic [LEN_W-1:0] ZERO_LEN_RESET = 16'd855;
    localparam logic [LEN_W-1:0] ONE_LEN_RESET  = 16'd1710;

    // samples = floor(t * 441 / 35000) = floor(t * 63 / 5000).
    // The reciprocal 63 * ceil(2^35 / 5000) gives the exact quotient for every
    // 16-bit t, so the count is the top bits of a single 16x29 product.
    localparam int RECIP_W     = 29;
    localparam int PROD_W      = LEN_W + RECIP_W;
    localparam int RECIP_SHIFT = 35;
    localparam int PULSE_CNT_W = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] PULSE_RECIP = 29'd432932724;

    localparam logic [COUNT_W-1:0] EDGE_RUN = 22'd45;
    localparam logic [STEP_W-1:0]  LAST_DATA_STEP = 4'd15;
    localparam logic [2:0]         BYTE_MSB = 3'd7;

    typedef struct packed {
        logic [LEN_W-1:0] zero_len;
        logic [LEN_W-1:0] one_len;
    } cfg_t;

    // Command held by the sequencer and its position within the command.
    typedef struct packed {
        logic              busy;
        logic [OP_W-1:0]   op;
        logic [DUR_W-1:0]  duration;
        logic [BYTE_W-1:0] data_byte;
        logic [USED_W-1:0] bits_used;
        logic [STEP_W-1:0] step;
        logic              level;
    } seq_state_t;

    typedef struct packed {
        logic               level;
        logic [COUNT_W-1:0] sample_count;
        logic               last;
    } run_t;

endpackage

// ===== rtl/core/tpr_cmd_if.sv =====
// Command channel of the tape pulse run generator: valid/ready plus one
// tape-block command. Depends on tpr_pkg for the field widths.
interface tpr_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [tpr_pkg::OP_W-1:0]   operation;
    logic [tpr_pkg::DUR_W-1:0]  duration;
    logic [tpr_pkg::BYTE_W-1:0] data_byte;
    logic [tpr_pkg::USED_W-1:0] bits_used;

    modport source (output valid, output operation, output duration,
                    output data_byte, output bits_used, input ready);
    modport sink   (input valid, input operation, input duration,
                    input data_byte, input bits_used, output ready);
endinterface

// ===== rtl/core/tpr_run_if.sv =====
// Run channel of the tape pulse run generator: valid/ready plus one run of
// output level. Depends on tpr_pkg for the field widths.
interface tpr_run_if;
    logic                        valid;
    logic                        ready;
    logic                        level;
    logic [tpr_pkg::COUNT_W-1:0] sample_count;
    logic                        last;

    modport source (output valid, output level, output sample_count,
                    output last, input ready);
    modport sink   (input valid, input level, input sample_count,
                    input last, output ready);
endinterface

// ===== rtl/core/tpr_apb_regs.sv =====
// APB configuration registers: zero_len at 0x0, one_len at 0x4.
// Depends on tpr_pkg.
module tpr_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpr_pkg::APB_AW-1:0]  paddr,
    input  logic [tpr_pkg::APB_DW-1:0]  pwdata,
    output logic [tpr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output tpr_pkg::cfg_t               cfg
);
    logic                       wr_en;
    logic                       reg_sel;
    logic [tpr_pkg::LEN_W-1:0]  zero_len_reg;
    logic [tpr_pkg::LEN_W-1:0]  one_len_reg;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_len_reg <= tpr_pkg::ZERO_LEN_RESET;
            one_len_reg  <= tpr_pkg::ONE_LEN_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == tpr_pkg::REG_ZERO_LEN)
            begin
                zero_len_reg <= pwdata[tpr_pkg::LEN_W-1:0];
            end
            else
            begin
                one_len_reg <= pwdata[tpr_pkg::LEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == tpr_pkg::REG_ZERO_LEN)
        begin
            prdata = tpr_pkg::APB_DW'(zero_len_reg);
        end
        else
        begin
            prdata = tpr_pkg::APB_DW'(one_len_reg);
        end
    end

    assign cfg.zero_len = zero_len_reg;
    assign cfg.one_len  = one_len_reg;
endmodule

// ===== rtl/core/tpr_cmd_seq.sv =====
// Command sequencer: holds the accepted command, steps through its runs and
// tracks the current output level. Depends on tpr_pkg and tpr_cmd_if.
module tpr_cmd_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    tpr_cmd_if.sink              cmd,
    input  logic                 adv,
    input  tpr_pkg::run_t        run,
    output tpr_pkg::seq_state_t  st
);
    logic                         busy_reg;
    logic [tpr_pkg::OP_W-1:0]     op_reg;
    logic [tpr_pkg::DUR_W-1:0]    dur_reg;
    logic [tpr_pkg::BYTE_W-1:0]   byte_reg;
    logic [tpr_pkg::USED_W-1:0]   used_reg;
    logic [tpr_pkg::STEP_W-1:0]   step_reg;
    logic                         level_reg;
    logic                         emit;
    logic                         accept;
    logic                         has_runs;

    // A run leaves for the output register whenever a command is active and
    // that register can take it.
    assign emit   = busy_reg && adv;
    assign cmd.ready = !busy_reg || (adv && run.last);
    assign accept = cmd.valid && cmd.ready;

    // Unknown operations and zero-length pauses produce no runs at all.
    always_comb
    begin
        case (cmd.operation)
            tpr_pkg::OP_PULSE: has_runs = 1'b1;
            tpr_pkg::OP_DATA:  has_runs = 1'b1;
            tpr_pkg::OP_PAUSE: has_runs = (cmd.duration != '0);
            default:           has_runs = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            level_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                level_reg <= run.level;
            end
            if (accept)
            begin
                busy_reg <= has_runs;
                step_reg <= '0;
            end
            else if (emit)
            begin
                busy_reg <= !run.last;
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= cmd.operation;
            dur_reg  <= cmd.duration;
            byte_reg <= cmd.data_byte;
            used_reg <= cmd.bits_used;
        end
    end

    assign st.busy      = busy_reg;
    assign st.op        = op_reg;
    assign st.duration  = dur_reg;
    assign st.data_byte = byte_reg;
    assign st.bits_used = used_reg;
    assign st.step      = step_reg;
    assign st.level     = level_reg;
endmodule

// ===== rtl/core/tpr_run_calc.sv =====
// Run calculator: forms the level, sample count and last flag of the run at
// the sequencer's current step. Depends on tpr_pkg.
module tpr_run_calc (
    input  tpr_pkg::seq_state_t  st,
    input  tpr_pkg::cfg_t        cfg,
    output tpr_pkg::run_t        run
);
    logic [2:0]                        bit_idx;
    logic                              bit_val;
    logic [tpr_pkg::LEN_W-1:0]         pulse_t;
    logic [tpr_pkg::PROD_W-1:0]        product;
    logic [tpr_pkg::PULSE_CNT_W-1:0]   pulse_samples;
    logic [tpr_pkg::COUNT_W-1:0]       pause_samples;

    // Two runs per bit, most significant bit first. Bits past bits_used go
    // out as zeros; bits_used of eight or more makes every bit real.
    assign bit_idx = st.step[tpr_pkg::STEP_W-1:1];
    assign bit_val = st.data_byte[tpr_pkg::BYTE_MSB - bit_idx]
                     && (st.bits_used[3] || ({1'b0, bit_idx} < st.bits_used));

    always_comb
    begin
        if (st.op == tpr_pkg::OP_DATA)
        begin
            pulse_t = bit_val ? cfg.one_len : cfg.zero_len;
        end
        else
        begin
            pulse_t = st.duration;
        end
    end

    assign product = tpr_pkg::PROD_W'(pulse_t) * tpr_pkg::PROD_W'(tpr_pkg::PULSE_RECIP);
    assign pulse_samples = product[tpr_pkg::PROD_W-1:tpr_pkg::RECIP_SHIFT];

    // 44 samples per millisecond, as shifts and adds.
    assign pause_samples = (tpr_pkg::COUNT_W'(st.duration) << 5)
                         + (tpr_pkg::COUNT_W'(st.duration) << 3)
                         + (tpr_pkg::COUNT_W'(st.duration) << 2);

    always_comb
    begin
        case (st.op)
            tpr_pkg::OP_PULSE:
            begin
                run.level        = !st.level;
                run.sample_count = tpr_pkg::COUNT_W'(pulse_samples);
                run.last         = 1'b1;
            end
            tpr_pkg::OP_DATA:
            begin
                run.level        = !st.level;
                run.sample_count = tpr_pkg::COUNT_W'(pulse_samples);
                run.last         = (st.step == tpr_pkg::LAST_DATA_STEP);
            end
            tpr_pkg::OP_PAUSE:
            begin
                // A short edge at the flipped level, then silence held low.
                if (!st.step[0])
                begin
                    run.level        = !st.level;
                    run.sample_count = tpr_pkg::EDGE_RUN;
                    run.last         = 1'b0;
                end
                else
                begin
                    run.level        = 1'b0;
                    run.sample_count = pause_samples;
                    run.last         = 1'b1;
                end
            end
            default:
            begin
                run.level        = st.level;
                run.sample_count = '0;
                run.last         = 1'b1;
            end
        endcase
    end
endmodule

// ===== rtl/core/tpr_out_stage.sv =====
// Output register of the run channel. It takes a new run whenever it is
// empty or its run is being taken. Depends on tpr_pkg and tpr_run_if.
module tpr_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  tpr_pkg::run_t   in_run,
    output logic            adv,
    tpr_run_if.source       run
);
    logic           valid_reg;
    tpr_pkg::run_t  run_reg;

    assign adv = !valid_reg || run.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            run_reg <= in_run;
        end
    end

    assign run.valid        = valid_reg;
    assign run.level        = run_reg.level;
    assign run.sample_count = run_reg.sample_count;
    assign run.last         = run_reg.last;
endmodule

// ===== rtl/core/tape_pulse_run_generator.sv =====
// Tape pulse run generator, top level.
// Depends on tpr_pkg, tpr_cmd_if, tpr_run_if and the tpr_* core modules.
//
// Commands arrive on cmd (valid/ready): a single pulse, a data byte or a
// pause. Each produces runs on run (valid/ready): a level and the number of
// 44.1 kHz samples it lasts, with last set on the final run of the command.
// A pulse gives one run, a pause two, a data byte sixteen; a zero-length
// pause or an unknown operation gives none. The sequencer emits one run per
// cycle while the output register can take it; the next item is accepted in
// the cycle its last run is emitted. An item's first run passes the sequencer
// registers, then the output register. The user must write zero_len (0x0) and
// one_len (0x4) over APB only while no command is in flight; the block itself
// does not enforce it. Reset clears the level to low, empties the output
// register and restores both length registers. When the receiver holds ready
// low the output register keeps its run and the sequencer waits in place.
module tape_pulse_run_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpr_pkg::APB_AW-1:0]  paddr,
    input  logic [tpr_pkg::APB_DW-1:0]  pwdata,
    output logic [tpr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    tpr_cmd_if.sink                     cmd,
    tpr_run_if.source                   run
);
    tpr_pkg::cfg_t        cfg;
    tpr_pkg::seq_state_t  st;
    tpr_pkg::run_t        next_run;
    logic                 adv;

    tpr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpr_cmd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .adv   (adv),
        .run   (next_run),
        .st    (st)
    );

    tpr_run_calc u_calc (
        .st  (st),
        .cfg (cfg),
        .run (next_run)
    );

    tpr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (st.busy),
        .in_run   (next_run),
        .adv      (adv),
        .run      (run)
    );
endmodule
